@@ src/bls_pkg.sv @@
`default_nettype none
package bls_pkg;

    localparam int SCREEN_BITS = 11;
    localparam int COLOR_BITS  = 16;

    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 11'd240;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 11'd320;

    // configuration register indexes
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // width of one decoded command word in the queue:
    // kind, four end point coordinates, span_x, neg_span_y, two directions,
    // initial error term and color
    function automatic int line_cmd_bits(input int coord_bits);
        return 7 * coord_bits + 6 + COLOR_BITS;
    endfunction

endpackage
`default_nettype wire

@@ src/bls_cmd_if.sv @@
`default_nettype none
interface bls_cmd_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [15:0]                  pixel_color;

    modport source (
        output valid, action, start_x, start_y, end_x, end_y, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, action, start_x, start_y, end_x, end_y, pixel_color,
        output ready
    );
endinterface
`default_nettype wire

@@ src/bls_pixel_if.sv @@
`default_nettype none
interface bls_pixel_if #(
    parameter int COORD_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic [15:0]                  out_color;
    logic                         out_valid;
    logic                         on_screen;
    logic                         last_pixel;

    modport source (
        output valid, out_x, out_y, out_color, out_valid, on_screen, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_color, out_valid, on_screen, last_pixel,
        output ready
    );
endinterface
`default_nettype wire

@@ src/bls_cfg_if.sv @@
`default_nettype none
interface bls_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [10:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface
`default_nettype wire

@@ src/bls_fifo.sv @@
`default_nettype none
module bls_fifo
    import bls_pkg::*;
#(
    parameter int WIDTH = 106,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next;
    logic [PW-1:0]    rptr_reg, rptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

@@ src/bls_front.sv @@
`default_nettype none
module bls_front
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    bls_cmd_if.sink                                 cmd,
    output logic                                    q_push,
    output logic [line_cmd_bits(COORD_BITS)-1:0]    q_data,
    input  wire logic                               q_full
);
    localparam int N = COORD_BITS;

    typedef struct packed {
        logic                  is_load;
        logic signed [N-1:0]   x0;
        logic signed [N-1:0]   y0;
        logic signed [N-1:0]   x1;
        logic signed [N-1:0]   y1;
        logic [N-1:0]          span_x;
        logic signed [N:0]     neg_span_y;
        logic                  dir_x_neg;
        logic                  dir_y_neg;
        logic signed [N+1:0]   err;
        logic [COLOR_BITS-1:0] color;
    } line_cmd_t;

    line_cmd_t         c;
    logic signed [N:0] dx, dy;
    logic [N:0]        abs_dx, abs_dy;

    assign cmd.ready = !q_full;
    assign q_push    = cmd.valid && !q_full;

    always_comb
    begin
        dx     = (N+1)'(cmd.end_x) - (N+1)'(cmd.start_x);
        dy     = (N+1)'(cmd.end_y) - (N+1)'(cmd.start_y);
        abs_dx = dx[N] ? -dx : dx;
        abs_dy = dy[N] ? -dy : dy;

        c            = '0;
        c.is_load    = (cmd.action == ACT_LOAD);
        c.x0         = cmd.start_x;
        c.y0         = cmd.start_y;
        c.x1         = cmd.end_x;
        c.y1         = cmd.end_y;
        c.span_x     = abs_dx[N-1:0];
        c.neg_span_y = -$signed(abs_dy);
        c.dir_x_neg  = !(cmd.start_x < cmd.end_x);
        c.dir_y_neg  = !(cmd.start_y < cmd.end_y);
        c.err        = $signed({2'b00, abs_dx[N-1:0]}) + (N+2)'(c.neg_span_y);
        c.color      = cmd.pixel_color;
    end

    assign q_data = c;
endmodule
`default_nettype wire

@@ src/bls_back.sv @@
`default_nettype none
module bls_back
    import bls_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [line_cmd_bits(COORD_BITS)-1:0] q_data,
    input  wire logic                               q_valid,
    output logic                                    q_pop,
    input  wire logic [SCREEN_BITS-1:0]             screen_width,
    input  wire logic [SCREEN_BITS-1:0]             screen_height,
    bls_pixel_if.source                             pixel
);
    localparam int N  = COORD_BITS;
    localparam int CW = (N > SCREEN_BITS) ? N : SCREEN_BITS;

    typedef struct packed {
        logic                  is_load;
        logic signed [N-1:0]   x0;
        logic signed [N-1:0]   y0;
        logic signed [N-1:0]   x1;
        logic signed [N-1:0]   y1;
        logic [N-1:0]          span_x;
        logic signed [N:0]     neg_span_y;
        logic                  dir_x_neg;
        logic                  dir_y_neg;
        logic signed [N+1:0]   err;
        logic [COLOR_BITS-1:0] color;
    } line_cmd_t;

    line_cmd_t c;

    logic signed [N-1:0]   cur_x_reg, cur_x_next;
    logic signed [N-1:0]   cur_y_reg, cur_y_next;
    logic signed [N-1:0]   tgt_x_reg, tgt_x_next;
    logic signed [N-1:0]   tgt_y_reg, tgt_y_next;
    logic [N-1:0]          span_x_reg, span_x_next;
    logic signed [N:0]     neg_y_reg, neg_y_next;
    logic                  dxn_reg, dxn_next;
    logic                  dyn_reg, dyn_next;
    logic signed [N+1:0]   err_reg, err_next;
    logic [COLOR_BITS-1:0] color_reg, color_next;
    logic                  active_reg, active_next;

    logic                  ov_reg, ov_next;
    logic signed [N-1:0]   ox_reg, ox_next;
    logic signed [N-1:0]   oy_reg, oy_next;
    logic [COLOR_BITS-1:0] ocolor_reg, ocolor_next;
    logic                  opix_reg, opix_next;
    logic                  oscreen_reg, oscreen_next;
    logic                  olast_reg, olast_next;

    logic                  take;
    logic signed [N+2:0]   e2;
    logic                  move_x, move_y;
    logic                  emit, last;
    logic [CW-1:0]         ux, uy;

    assign c     = q_data;
    assign take  = q_valid && (!ov_reg || pixel.ready);
    assign q_pop = take;

    always_comb
    begin
        e2     = (N+3)'(err_reg) <<< 1;
        move_x = (e2 >= (N+3)'(neg_y_reg));
        move_y = (e2 <= $signed({3'b000, span_x_reg}));
    end

    // line state update
    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        span_x_next = span_x_reg;
        neg_y_next  = neg_y_reg;
        dxn_next    = dxn_reg;
        dyn_next    = dyn_reg;
        err_next    = err_reg;
        color_next  = color_reg;
        emit        = 1'b0;
        if (take)
        begin
            if (c.is_load)
            begin
                cur_x_next  = c.x0;
                cur_y_next  = c.y0;
                tgt_x_next  = c.x1;
                tgt_y_next  = c.y1;
                span_x_next = c.span_x;
                neg_y_next  = c.neg_span_y;
                dxn_next    = c.dir_x_neg;
                dyn_next    = c.dir_y_neg;
                err_next    = c.err;
                color_next  = c.color;
                emit        = 1'b1;
            end
            else if (active_reg)
            begin
                err_next = err_reg
                         + (move_x ? (N+2)'(neg_y_reg) : '0)
                         + (move_y ? $signed({2'b00, span_x_reg}) : '0);
                if (move_x)
                begin
                    cur_x_next = cur_x_reg + (dxn_reg ? {N{1'b1}} : N'(1));
                end
                if (move_y)
                begin
                    cur_y_next = cur_y_reg + (dyn_reg ? {N{1'b1}} : N'(1));
                end
                emit = 1'b1;
            end
        end
    end

    // result formation
    always_comb
    begin
        last = (cur_x_next == tgt_x_next) && (cur_y_next == tgt_y_next);
        ux   = CW'($unsigned(cur_x_next));
        uy   = CW'($unsigned(cur_y_next));

        active_next  = active_reg;
        ov_next      = ov_reg && !pixel.ready;
        ox_next      = ox_reg;
        oy_next      = oy_reg;
        ocolor_next  = ocolor_reg;
        opix_next    = opix_reg;
        oscreen_next = oscreen_reg;
        olast_next   = olast_reg;
        if (take)
        begin
            ov_next = 1'b1;
            if (emit)
            begin
                active_next  = !last;
                ox_next      = cur_x_next;
                oy_next      = cur_y_next;
                ocolor_next  = color_next;
                opix_next    = 1'b1;
                oscreen_next = !cur_x_next[N-1] && !cur_y_next[N-1]
                             && (ux < CW'(screen_width)) && (uy < CW'(screen_height));
                olast_next   = last;
            end
            else
            begin
                // step with no line: empty result
                ox_next      = '0;
                oy_next      = '0;
                ocolor_next  = '0;
                opix_next    = 1'b0;
                oscreen_next = 1'b0;
                olast_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        tgt_x_reg   <= tgt_x_next;
        tgt_y_reg   <= tgt_y_next;
        span_x_reg  <= span_x_next;
        neg_y_reg   <= neg_y_next;
        dxn_reg     <= dxn_next;
        dyn_reg     <= dyn_next;
        err_reg     <= err_next;
        color_reg   <= color_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        ocolor_reg  <= ocolor_next;
        opix_reg    <= opix_next;
        oscreen_reg <= oscreen_next;
        olast_reg   <= olast_next;
    end

    assign pixel.valid      = ov_reg;
    assign pixel.out_x      = ox_reg;
    assign pixel.out_y      = oy_reg;
    assign pixel.out_color  = ocolor_reg;
    assign pixel.out_valid  = opix_reg;
    assign pixel.on_screen  = oscreen_reg;
    assign pixel.last_pixel = olast_reg;
endmodule
`default_nettype wire

@@ src/bresenham_line_stepper.sv @@
// Each accepted item passes the command queue, then the output register.
// Throughput: one item per cycle unless pixel.ready holds the output; one
// error-term add/compare per pixel sets it.
// Reset: asynchronous, active low; empties the queue, drops any active line
// and the pending result, and restores screen size to 240 x 320.
`default_nettype none
module bresenham_line_stepper
    import bls_pkg::*;
#(
    parameter int COORD_BITS  = 12,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bls_cmd_if.sink     cmd,
    bls_pixel_if.source pixel,
    bls_cfg_if.sink     cfg
);
    localparam int QW = line_cmd_bits(COORD_BITS);

    logic [SCREEN_BITS-1:0] width_reg, width_next;
    logic [SCREEN_BITS-1:0] height_reg, height_next;

    logic          q_push, q_full, q_pop, q_empty;
    logic [QW-1:0] q_wdata, q_rdata;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SCREEN_WIDTH:  width_next  = cfg.data;
                CFG_SCREEN_HEIGHT: height_next = cfg.data;
                default:           width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RESET;
            height_reg <= SCREEN_HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    bls_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .cmd    (cmd),
        .q_push (q_push),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    bls_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    bls_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_rdata),
        .q_valid       (!q_empty),
        .q_pop         (q_pop),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .pixel         (pixel)
    );
endmodule
`default_nettype wire

@@ bench/bresenham_line_stepper_tb.sv @@
`default_nettype none
module bresenham_line_stepper_tb
    import bls_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS     = 12;
    localparam int COORD_MAX      = 2 ** (COORD_BITS - 1) - 1;
    localparam int COORD_MIN      = -(2 ** (COORD_BITS - 1));
    localparam int STALL_LIMIT    = 5000;
    localparam int SEGMENT_ITEMS  = 155;
    localparam int MAX_LINE_STEPS = 48;

    typedef struct {
        logic                         action;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
        logic [COLOR_BITS-1:0]        color;
        logic                         hold_for_drain;
    } line_cmd_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic [COLOR_BITS-1:0]        color;
        logic                         valid;
        logic                         visible;
        logic                         last;
    } pixel_t;

    logic clk;
    logic rst_n;

    bls_cmd_if #(.COORD_BITS(COORD_BITS))   cmd ();
    bls_pixel_if #(.COORD_BITS(COORD_BITS)) pixel ();
    bls_cfg_if                              cfg ();

    bresenham_line_stepper #(.COORD_BITS(COORD_BITS)) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .pixel (pixel),
        .cfg   (cfg)
    );

    // line tracer state, mirrors the block
    logic signed [COORD_BITS-1:0] pen_x      = '0;
    logic signed [COORD_BITS-1:0] pen_y      = '0;
    logic signed [COORD_BITS-1:0] goal_x     = '0;
    logic signed [COORD_BITS-1:0] goal_y     = '0;
    logic [COORD_BITS-1:0]        run_x      = '0;
    logic signed [COORD_BITS:0]   neg_rise_y = '0;
    logic signed [COORD_BITS+1:0] err_acc    = '0;
    logic                         x_back     = 1'b0;
    logic                         y_back     = 1'b0;
    logic                         tracing    = 1'b0;
    logic [COLOR_BITS-1:0]        ink        = '0;
    logic [SCREEN_BITS-1:0]       scr_w      = SCREEN_WIDTH_RESET;
    logic [SCREEN_BITS-1:0]       scr_h      = SCREEN_HEIGHT_RESET;

    line_cmd_t cmd_backlog[$];
    pixel_t    pending_pixels[$];
    line_cmd_t on_bus;
    pixel_t    want;

    int src_idle_pct = 21;
    int snk_idle_pct = 70;
    int fail_count   = 0;
    int queued_items = 0;
    int quiet_cycles = 0;

    function automatic pixel_t trace_pixel(input line_cmd_t c);
        pixel_t p;
        int     x0;
        int     y0;
        int     x1;
        int     y1;
        int     e2;
        p = '{default: '0};
        if (c.action == ACT_LOAD)
        begin
            x0 = c.sx;
            y0 = c.sy;
            x1 = c.ex;
            y1 = c.ey;
            pen_x      = c.sx;
            pen_y      = c.sy;
            goal_x     = c.ex;
            goal_y     = c.ey;
            run_x      = COORD_BITS'(x1 > x0 ? x1 - x0 : x0 - x1);
            neg_rise_y = (COORD_BITS+1)'(y1 > y0 ? y0 - y1 : y1 - y0);
            x_back     = !(x0 < x1);
            y_back     = !(y0 < y1);
            err_acc    = (COORD_BITS+2)'(int'(run_x) + int'(neg_rise_y));
            ink        = c.color;
            tracing    = 1'b1;
        end
        else if (!tracing)
        begin
            return p;
        end
        else
        begin
            e2 = 2 * int'(err_acc);
            if (e2 >= int'(neg_rise_y))
            begin
                err_acc = (COORD_BITS+2)'(int'(err_acc) + int'(neg_rise_y));
                pen_x   = COORD_BITS'(int'(pen_x) + (x_back ? -1 : 1));
            end
            if (e2 <= int'(run_x))
            begin
                err_acc = (COORD_BITS+2)'(int'(err_acc) + int'(run_x));
                pen_y   = COORD_BITS'(int'(pen_y) + (y_back ? -1 : 1));
            end
        end
        p.x       = pen_x;
        p.y       = pen_y;
        p.color   = ink;
        p.valid   = 1'b1;
        p.visible = int'(pen_x) >= 0 && int'(pen_y) >= 0 &&
                    int'(pen_x) < int'(scr_w) && int'(pen_y) < int'(scr_h);
        p.last    = pen_x == goal_x && pen_y == goal_y;
        if (p.last)
            tracing = 1'b0;
        return p;
    endfunction

    function automatic int fit_coord(input int v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 2 ** COORD_BITS - 1)) + COORD_MIN;
    endfunction

    // bias line origins toward the screen corners and edges
    function automatic int pick_base(input int limit);
        int v;
        case ($urandom_range(0, 3))
            0:       v = int'($urandom_range(0, 16)) - 8;
            1:       v = limit + int'($urandom_range(0, 16)) - 8;
            2:       v = rand_coord();
            default: v = int'($urandom_range(0, 300));
        endcase
        return fit_coord(v);
    endfunction

    function automatic void check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    task automatic add_load(input int x0, input int y0, input int x1, input int y1,
                            input logic [COLOR_BITS-1:0] color, input logic drain);
        line_cmd_t c;
        c.action         = ACT_LOAD;
        c.sx             = COORD_BITS'(x0);
        c.sy             = COORD_BITS'(y0);
        c.ex             = COORD_BITS'(x1);
        c.ey             = COORD_BITS'(y1);
        c.color          = color;
        c.hold_for_drain = drain;
        cmd_backlog.push_back(c);
        queued_items++;
    endtask

    // end points and color ride along with random content and must be ignored
    task automatic add_step();
        line_cmd_t c;
        c.action         = ACT_STEP;
        c.sx             = COORD_BITS'($urandom);
        c.sy             = COORD_BITS'($urandom);
        c.ex             = COORD_BITS'($urandom);
        c.ey             = COORD_BITS'($urandom);
        c.color          = COLOR_BITS'($urandom);
        c.hold_for_drain = 1'b0;
        cmd_backlog.push_back(c);
        queued_items++;
    endtask

    task automatic queue_random_lines(input int count);
        int first;
        int x0;
        int y0;
        int x1;
        int y1;
        int span;
        int n;
        first = queued_items;
        while (queued_items - first < count)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                if ($urandom_range(0, 1) == 1)
                    add_step();
                else
                    add_load(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             COLOR_BITS'($urandom), 1'b0);
            end
            else
            begin
                x0 = pick_base(int'(scr_w));
                y0 = pick_base(int'(scr_h));
                if ($urandom_range(0, 6) == 0)
                begin
                    x1 = rand_coord();
                    y1 = rand_coord();
                end
                else
                begin
                    x1 = fit_coord(x0 + int'($urandom_range(0, 30)) - 15);
                    y1 = fit_coord(y0 + int'($urandom_range(0, 30)) - 15);
                end
                add_load(x0, y0, x1, y1, COLOR_BITS'($urandom), $urandom_range(0, 49) == 0);
                span = (x1 > x0) ? x1 - x0 : x0 - x1;
                if (((y1 > y0) ? y1 - y0 : y0 - y1) > span)
                    span = (y1 > y0) ? y1 - y0 : y0 - y1;
                // run to the end point, past it, or cut the line short
                case ($urandom_range(0, 9))
                    7:       n = span + int'($urandom_range(1, 3));
                    8, 9:    n = int'($urandom_range(0, span));
                    default: n = span;
                endcase
                if (n > MAX_LINE_STEPS)
                    n = MAX_LINE_STEPS;
                repeat (n)
                    add_step();
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (cmd_backlog.size() > 0 || cmd.valid || pending_pixels.size() > 0);
    endtask

    task automatic set_screen(input logic idx, input logic [SCREEN_BITS-1:0] value);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == CFG_SCREEN_WIDTH)
            scr_w = value;
        else
            scr_h = value;
    endtask

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
                pending_pixels.push_back(trace_pixel(on_bus));
            if (!cmd.valid || cmd.ready)
            begin
                if (cmd_backlog.size() > 0 &&
                    !(cmd_backlog[0].hold_for_drain && pending_pixels.size() > 0) &&
                    $urandom_range(0, 99) >= src_idle_pct)
                begin
                    on_bus = cmd_backlog.pop_front();
                    cmd.valid       <= 1'b1;
                    cmd.action      <= on_bus.action;
                    cmd.start_x     <= on_bus.sx;
                    cmd.start_y     <= on_bus.sy;
                    cmd.end_x       <= on_bus.ex;
                    cmd.end_y       <= on_bus.ey;
                    cmd.pixel_color <= on_bus.color;
                end
                else
                begin
                    cmd.valid <= 1'b0;
                end
            end
        end
    end

    // pixel monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel.ready <= 1'b0;
        end
        else
        begin
            if (pixel.valid && pixel.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("pixel transaction with no expectation pending");
                    fail_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    check_field("out_x", int'(want.x), int'(pixel.out_x));
                    check_field("out_y", int'(want.y), int'(pixel.out_y));
                    check_field("out_color", int'(want.color), int'(pixel.out_color));
                    check_field("out_valid", int'(want.valid), int'(pixel.out_valid));
                    check_field("on_screen", int'(want.visible), int'(pixel.on_screen));
                    check_field("last_pixel", int'(want.last), int'(pixel.last_pixel));
                end
            end
            pixel.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // watchdog: count cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd.valid && cmd.ready) || (pixel.valid && pixel.ready) ||
                (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial
    begin
        cmd.valid       = 1'b0;
        cmd.action      = ACT_LOAD;
        cmd.start_x     = '0;
        cmd.start_y     = '0;
        cmd.end_x       = '0;
        cmd.end_y       = '0;
        cmd.pixel_color = '0;
        pixel.ready     = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = CFG_SCREEN_WIDTH;
        cfg.data        = '0;
        rst_n           = 1'b0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed lines on the reset screen size
        add_step();
        add_load(0, 0, 0, 0, 16'h1234, 1'b0);
        add_step();
        add_load(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 16'hFFFF, 1'b0);
        add_step();
        add_step();
        add_load(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 16'h0000, 1'b0);
        add_step();
        add_load(10, 5, 14, 5, 16'hF800, 1'b1);
        repeat (4)
            add_step();
        add_load(3, 8, 3, 5, 16'h07E0, 1'b0);
        repeat (3)
            add_step();
        add_load(238, 318, 241, 321, 16'h001F, 1'b0);
        repeat (3)
            add_step();
        add_step();
        add_load(-1, -1, -3, 0, 16'hAAAA, 1'b0);
        repeat (2)
            add_step();
        wait_drained();

        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg / 2)
                0:
                begin
                    src_idle_pct = 21;
                    snk_idle_pct = 70;
                end
                1:
                begin
                    src_idle_pct = 70;
                    snk_idle_pct = 21;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            case (seg)
                0:
                begin
                    set_screen(CFG_SCREEN_WIDTH, 11'd1);
                    set_screen(CFG_SCREEN_HEIGHT, 11'd1);
                end
                1:
                begin
                    set_screen(CFG_SCREEN_WIDTH, 11'd2047);
                    set_screen(CFG_SCREEN_HEIGHT, 11'd2047);
                end
                2:
                begin
                    set_screen(CFG_SCREEN_WIDTH, 11'd0);
                    set_screen(CFG_SCREEN_HEIGHT, 11'd0);
                end
                4:
                begin
                    set_screen(CFG_SCREEN_WIDTH, 11'd320);
                    set_screen(CFG_SCREEN_HEIGHT, 11'd240);
                end
                default:
                begin
                    set_screen(CFG_SCREEN_WIDTH, SCREEN_BITS'($urandom_range(1, 2047)));
                    set_screen(CFG_SCREEN_HEIGHT, SCREEN_BITS'($urandom_range(1, 2047)));
                end
            endcase
            queue_random_lines(SEGMENT_ITEMS);
            wait_drained();
        end

        repeat (10)
            @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
`default_nettype wire
